// ----- sv/smalu_pkg.sv -----
// Shared opcodes, status codes, widths and control types of the stack machine ALU.
`timescale 1ns / 1ps

package smalu_pkg;

    // Default sizes of the operand stack
    localparam int DEF_STACK_DEPTH = 128;
    localparam int DEF_WORD_WIDTH  = 32;

    // Port field widths
    localparam int REQ_W       = 4;
    localparam int IMM_W       = 32;
    localparam int KIND_W      = 2;
    localparam int VAL_W       = 32;
    localparam int STAT_W      = 3;
    localparam int DEPTH_OUT_W = 8;

    // Bits of the multiplier operand consumed per cycle
    localparam int MUL_DIGIT = 8;

    // Opcodes
    localparam logic [REQ_W-1:0] OP_HALT    = 4'd0;
    localparam logic [REQ_W-1:0] OP_PUSH    = 4'd1;
    localparam logic [REQ_W-1:0] OP_PRINT   = 4'd2;
    localparam logic [REQ_W-1:0] OP_PRINTLN = 4'd3;
    localparam logic [REQ_W-1:0] OP_BRANCH  = 4'd4;
    localparam logic [REQ_W-1:0] OP_ADD     = 4'd5;
    localparam logic [REQ_W-1:0] OP_SUB     = 4'd6;
    localparam logic [REQ_W-1:0] OP_MUL     = 4'd7;
    localparam logic [REQ_W-1:0] OP_DIV     = 4'd8;
    localparam logic [REQ_W-1:0] OP_LT      = 4'd9;
    localparam logic [REQ_W-1:0] OP_EQ      = 4'd10;
    localparam logic [REQ_W-1:0] OP_POP     = 4'd11;
    localparam logic [REQ_W-1:0] OP_NOP     = 4'd12;

    // Print kinds
    localparam logic [KIND_W-1:0] PK_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] PK_PRINT   = 2'd1;
    localparam logic [KIND_W-1:0] PK_PRINTLN = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd2;
    localparam logic [STAT_W-1:0] ST_DIVZERO   = 3'd3;
    localparam logic [STAT_W-1:0] ST_HALTED    = 3'd4;

    // Request to the multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } t_md_ctrl;

endpackage

// ----- sv/smalu_stack_ram.sv -----
// Operand stack memory: one write port, two registered read ports.
`timescale 1ns / 1ps

module smalu_stack_ram #(
    parameter int DEPTH = smalu_pkg::DEF_STACK_DEPTH,
    parameter int WIDTH = smalu_pkg::DEF_WORD_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr0,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr1,
    output logic [WIDTH-1:0]         o_rd_data0,
    output logic [WIDTH-1:0]         o_rd_data1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read two entries; the read data is registered
    always_ff @(posedge i_clk) begin
        o_rd_data0 <= r_mem[i_rd_addr0];
        o_rd_data1 <= r_mem[i_rd_addr1];
    end

endmodule

// ----- sv/smalu_muldiv.sv -----
// Iterative multiplier (one digit per cycle) and signed restoring divider (one bit per cycle).
`timescale 1ns / 1ps

module smalu_muldiv #(
    parameter int WORD_WIDTH = smalu_pkg::DEF_WORD_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  smalu_pkg::t_md_ctrl   i_ctrl,
    input  logic [WORD_WIDTH-1:0] i_a,
    input  logic [WORD_WIDTH-1:0] i_b,
    output logic                  o_done,
    output logic [WORD_WIDTH-1:0] o_result
);

    localparam int W         = WORD_WIDTH;
    localparam int DIG       = smalu_pkg::MUL_DIGIT;
    localparam int MUL_STEPS = (W + DIG - 1) / DIG;
    localparam int CNT_W     = $clog2(W + 1);

    logic             r_busy;
    logic             r_done;
    logic             r_is_div;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_acc;   // product or partial remainder
    logic [W-1:0]     r_x;     // shifted multiplicand or dividend/quotient
    logic [W-1:0]     r_y;     // shifted multiplier or divisor magnitude

    logic [W-1:0]     mag_a;
    logic [W-1:0]     mag_b;
    logic [W+DIG-1:0] mul_pp;
    logic [W:0]       rem_sh;
    logic [W:0]       rem_diff;

    // Operand magnitudes for the divider
    assign mag_a = i_a[W-1] ? ({W{1'b0}} - i_a) : i_a;
    assign mag_b = i_b[W-1] ? ({W{1'b0}} - i_b) : i_b;

    // One partial product and one trial subtraction per cycle
    assign mul_pp   = r_x * r_y[DIG-1:0];
    assign rem_sh   = {r_acc, r_x[W-1]};
    assign rem_diff = rem_sh - {1'b0, r_y};

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: load operands, then advance one step per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_is_div <= i_ctrl.is_div;
            r_acc    <= '0;
            r_neg    <= i_a[W-1] ^ i_b[W-1];
            if (i_ctrl.is_div) begin
                r_x   <= mag_a;
                r_y   <= mag_b;
                r_cnt <= CNT_W'(W);
            end else begin
                r_x   <= i_a;
                r_y   <= i_b;
                r_cnt <= CNT_W'(MUL_STEPS);
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_is_div) begin
                if (!rem_diff[W]) begin
                    r_acc <= rem_diff[W-1:0];
                    r_x   <= {r_x[W-2:0], 1'b1};
                end else begin
                    r_acc <= rem_sh[W-1:0];
                    r_x   <= {r_x[W-2:0], 1'b0};
                end
            end else begin
                r_acc <= r_acc + mul_pp[W-1:0];
                r_x   <= r_x << DIG;
                r_y   <= r_y >> DIG;
            end
        end
    end

    // Apply the quotient sign on the way out
    assign o_done   = r_done;
    assign o_result = r_is_div ? (r_neg ? ({W{1'b0}} - r_x) : r_x) : r_acc;

endmodule

// ----- sv/stack_machine_alu_core.sv -----
// Top level of the stack machine ALU: instruction sequencer around the stack memory.
`timescale 1ns / 1ps

// Stack machine ALU. Each input item is one instruction (opcode and immediate);
// each instruction gives exactly one result item: print kind, printed value,
// status and the stack depth after it. Items are taken on i_in_valid with
// o_in_stall low and given on o_out_valid, held until i_out_stall is low.
// The operand stack lives in a RAM with two registered read ports; the
// sequencer reads the two top entries in the cycle an item is accepted,
// evaluates in the next and writes back at most one entry.
// Most opcodes go from S_IDLE through S_EXEC to S_DONE, which loads the
// output register; a multiply or a divide by a nonzero value waits in S_WAIT
// until the shared iterative multiply/divide unit is done.
// A new item is taken only back in S_IDLE, after the last result has gone
// to the output register; it may be taken while that result still waits there.
// A stalled receiver holds the result; the sequencer then waits with its
// next result and stalls the input side.
// Reset (synchronous, active low) empties the stack and clears the halted
// flag; stack contents are not cleared, no entry's value is used before written.
module stack_machine_alu_core #(
    parameter int STACK_DEPTH = smalu_pkg::DEF_STACK_DEPTH,
    parameter int WORD_WIDTH  = smalu_pkg::DEF_WORD_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [smalu_pkg::REQ_W-1:0]         i_req_type,
    input  logic signed [smalu_pkg::IMM_W-1:0]  i_immediate,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [smalu_pkg::KIND_W-1:0]        o_print_kind,
    output logic signed [smalu_pkg::VAL_W-1:0]  o_print_value,
    output logic [smalu_pkg::STAT_W-1:0]        o_status,
    output logic [smalu_pkg::DEPTH_OUT_W-1:0]   o_depth_after
);

    localparam int W  = WORD_WIDTH;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                        r_state;
    logic [1:0]                        n_state;
    logic [DW-1:0]                     r_depth;
    logic [DW-1:0]                     n_depth;
    logic                              r_halted;
    logic                              n_halted;
    logic [smalu_pkg::REQ_W-1:0]       r_op;
    logic [smalu_pkg::IMM_W-1:0]       r_imm;
    logic [smalu_pkg::KIND_W-1:0]      r_res_kind;
    logic [smalu_pkg::KIND_W-1:0]      n_res_kind;
    logic [smalu_pkg::VAL_W-1:0]       r_res_value;
    logic [smalu_pkg::VAL_W-1:0]       n_res_value;
    logic [smalu_pkg::STAT_W-1:0]      r_res_status;
    logic [smalu_pkg::STAT_W-1:0]      n_res_status;
    logic                              r_out_valid;

    logic                              in_accept;
    logic                              out_free;
    logic                              wr_en;
    logic [AW-1:0]                     wr_addr;
    logic [W-1:0]                      wr_data;
    logic [AW-1:0]                     rd_addr_b;
    logic [AW-1:0]                     rd_addr_a;
    logic [W-1:0]                      op_b;
    logic [W-1:0]                      op_a;
    logic                              op_lt;
    smalu_pkg::t_md_ctrl               md_ctrl;
    logic                              md_done;
    logic [W-1:0]                      md_result;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // Top two entries, read on every cycle from the current depth
    assign rd_addr_b = AW'(r_depth - DW'(1));
    assign rd_addr_a = AW'(r_depth - DW'(2));

    smalu_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (W)
    ) u_stack_ram (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .i_rd_addr0 (rd_addr_b),
        .i_rd_addr1 (rd_addr_a),
        .o_rd_data0 (op_b),
        .o_rd_data1 (op_a)
    );

    smalu_muldiv #(
        .WORD_WIDTH (W)
    ) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (md_ctrl),
        .i_a      (op_a),
        .i_b      (op_b),
        .o_done   (md_done),
        .o_result (md_result)
    );

    assign op_lt = $signed(op_a) < $signed(op_b);

    // Execute the instruction and write back the stack
    always_comb begin
        n_state      = r_state;
        n_depth      = r_depth;
        n_halted     = r_halted;
        n_res_kind   = r_res_kind;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        wr_en        = 1'b0;
        wr_addr      = rd_addr_a;
        wr_data      = md_result;
        md_ctrl      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_state      = S_DONE;
                n_res_kind   = smalu_pkg::PK_NONE;
                n_res_value  = '0;
                n_res_status = smalu_pkg::ST_OK;
                if (r_halted) begin
                    n_res_status = smalu_pkg::ST_HALTED;
                end else begin
                    unique case (r_op)
                        smalu_pkg::OP_HALT: begin
                            n_halted     = 1'b1;
                            n_res_status = smalu_pkg::ST_HALTED;
                        end
                        smalu_pkg::OP_PUSH: begin
                            if (r_depth == DW'(STACK_DEPTH)) begin
                                n_res_status = smalu_pkg::ST_OVERFLOW;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = AW'(r_depth);
                                wr_data = W'($signed(r_imm));
                                n_depth = r_depth + DW'(1);
                            end
                        end
                        smalu_pkg::OP_PRINT, smalu_pkg::OP_PRINTLN, smalu_pkg::OP_POP: begin
                            if (r_depth == '0) begin
                                n_res_status = smalu_pkg::ST_UNDERFLOW;
                            end else begin
                                n_depth = r_depth - DW'(1);
                                if (r_op == smalu_pkg::OP_PRINT) begin
                                    n_res_kind  = smalu_pkg::PK_PRINT;
                                    n_res_value = smalu_pkg::VAL_W'(op_b);
                                end else if (r_op == smalu_pkg::OP_PRINTLN) begin
                                    n_res_kind  = smalu_pkg::PK_PRINTLN;
                                    n_res_value = smalu_pkg::VAL_W'(op_b);
                                end
                            end
                        end
                        smalu_pkg::OP_ADD, smalu_pkg::OP_SUB, smalu_pkg::OP_MUL,
                        smalu_pkg::OP_DIV, smalu_pkg::OP_LT, smalu_pkg::OP_EQ: begin
                            if (r_depth < DW'(2)) begin
                                n_res_status = smalu_pkg::ST_UNDERFLOW;
                            end else if (r_op == smalu_pkg::OP_MUL) begin
                                md_ctrl.start = 1'b1;
                                n_state       = S_WAIT;
                            end else if (r_op == smalu_pkg::OP_DIV) begin
                                if (op_b == '0) begin
                                    n_res_status = smalu_pkg::ST_DIVZERO;
                                end else begin
                                    md_ctrl.start  = 1'b1;
                                    md_ctrl.is_div = 1'b1;
                                    n_state        = S_WAIT;
                                end
                            end else begin
                                wr_en   = 1'b1;
                                n_depth = r_depth - DW'(1);
                                if (r_op == smalu_pkg::OP_ADD) begin
                                    wr_data = op_a + op_b;
                                end else if (r_op == smalu_pkg::OP_SUB) begin
                                    wr_data = op_a - op_b;
                                end else if (r_op == smalu_pkg::OP_LT) begin
                                    wr_data = W'(op_lt);
                                end else begin
                                    wr_data = W'(op_a == op_b);
                                end
                            end
                        end
                        default: begin
                            // branch, nop and unused codes do nothing
                        end
                    endcase
                end
            end

            S_WAIT: begin
                if (md_done) begin
                    wr_en   = 1'b1;
                    n_depth = r_depth - DW'(1);
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_depth  <= n_depth;
            r_halted <= n_halted;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Latch the item and the pending result
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op  <= i_req_type;
            r_imm <= i_immediate;
        end
        r_res_kind   <= n_res_kind;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
    end

    // Output register: load when empty or being drained
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            o_print_kind  <= r_res_kind;
            o_print_value <= r_res_value;
            o_status      <= r_res_status;
            o_depth_after <= smalu_pkg::DEPTH_OUT_W'(r_depth);
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the stack machine ALU core.
`timescale 1ns / 1ps

module tb_top;

    localparam int STACK_N      = smalu_pkg::DEF_STACK_DEPTH;
    localparam int WORD         = smalu_pkg::DEF_WORD_WIDTH;
    localparam int RANDOM_ITEMS = 1320;
    localparam int HOLD_CYCLES  = 90;
    localparam int DRAIN_CYCLES = 100;
    localparam int QUIET_LIMIT  = 1000;

    // Opcodes the block treats as no-ops
    localparam logic [smalu_pkg::REQ_W-1:0] OP_UNUSED_LO = 4'd13;
    localparam logic [smalu_pkg::REQ_W-1:0] OP_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic [smalu_pkg::REQ_W-1:0] op;
        logic [smalu_pkg::IMM_W-1:0] imm;
    } t_instr;

    typedef struct packed {
        logic [smalu_pkg::KIND_W-1:0]      kind;
        logic [smalu_pkg::VAL_W-1:0]       value;
        logic [smalu_pkg::STAT_W-1:0]      status;
        logic [smalu_pkg::DEPTH_OUT_W-1:0] depth;
    } t_instr_result;

    // DUT ports; the inputs are known from time zero
    logic                                i_clk       = 1'b0;
    logic                                i_rst_n     = 1'b0;
    logic                                i_in_valid  = 1'b0;
    logic [smalu_pkg::REQ_W-1:0]         i_req_type  = smalu_pkg::OP_NOP;
    logic signed [smalu_pkg::IMM_W-1:0]  i_immediate = '0;
    logic                                i_out_stall = 1'b0;
    logic                                o_in_stall;
    logic                                o_out_valid;
    logic [smalu_pkg::KIND_W-1:0]        o_print_kind;
    logic signed [smalu_pkg::VAL_W-1:0]  o_print_value;
    logic [smalu_pkg::STAT_W-1:0]        o_status;
    logic [smalu_pkg::DEPTH_OUT_W-1:0]   o_depth_after;

    stack_machine_alu_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_immediate   (i_immediate),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_print_kind  (o_print_kind),
        .o_print_value (o_print_value),
        .o_status      (o_status),
        .o_depth_after (o_depth_after)
    );

    always #1 i_clk = ~i_clk;

    wire in_fire  = i_rst_n && i_in_valid && !o_in_stall;
    wire out_fire = i_rst_n && o_out_valid && !i_out_stall;

    // Program waiting to be issued and results of issued instructions
    t_instr        program_q[$];
    t_instr_result retire_q[$];

    // Shadow machine state
    logic [WORD-1:0] stk_mem [STACK_N];
    int              stk_depth  = 0;
    bit              is_halted  = 1'b0;

    // Run bookkeeping
    int program_total = 0;
    int instr_taken   = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int peak_depth    = 0;
    int status_hits [8];
    int prints_seen   = 0;
    bit in_fire_q     = 1'b0;
    int gen_depth     = 0;

    // Execute one instruction on the shadow machine
    function automatic t_instr_result execute_instr(logic [smalu_pkg::REQ_W-1:0] op,
                                                    logic [smalu_pkg::IMM_W-1:0] imm);
        t_instr_result   r;
        logic [WORD-1:0] a, b, res, ma, mb;
        r        = '0;
        r.kind   = smalu_pkg::PK_NONE;
        r.status = smalu_pkg::ST_OK;
        res      = '0;
        if (is_halted) begin
            r.status = smalu_pkg::ST_HALTED;
        end else begin
            case (op)
                smalu_pkg::OP_HALT: begin
                    is_halted = 1'b1;
                    r.status  = smalu_pkg::ST_HALTED;
                end
                smalu_pkg::OP_PUSH: begin
                    if (stk_depth >= STACK_N) begin
                        r.status = smalu_pkg::ST_OVERFLOW;
                    end else begin
                        stk_mem[stk_depth] = WORD'(imm);
                        stk_depth++;
                    end
                end
                smalu_pkg::OP_PRINT, smalu_pkg::OP_PRINTLN, smalu_pkg::OP_POP: begin
                    if (stk_depth < 1) begin
                        r.status = smalu_pkg::ST_UNDERFLOW;
                    end else begin
                        stk_depth--;
                        if (op != smalu_pkg::OP_POP) begin
                            r.kind  = (op == smalu_pkg::OP_PRINT) ? smalu_pkg::PK_PRINT
                                                                  : smalu_pkg::PK_PRINTLN;
                            r.value = smalu_pkg::VAL_W'(stk_mem[stk_depth]);
                        end
                    end
                end
                smalu_pkg::OP_ADD, smalu_pkg::OP_SUB, smalu_pkg::OP_MUL,
                smalu_pkg::OP_DIV, smalu_pkg::OP_LT, smalu_pkg::OP_EQ: begin
                    if (stk_depth < 2) begin
                        r.status = smalu_pkg::ST_UNDERFLOW;
                    end else begin
                        b = stk_mem[stk_depth-1];
                        a = stk_mem[stk_depth-2];
                        case (op)
                            smalu_pkg::OP_ADD: res = a + b;
                            smalu_pkg::OP_SUB: res = a - b;
                            smalu_pkg::OP_MUL: res = a * b;
                            smalu_pkg::OP_DIV: begin
                                // Divide magnitudes, then fix the sign; min / -1 wraps
                                if (b == '0) begin
                                    r.status = smalu_pkg::ST_DIVZERO;
                                end else begin
                                    ma  = a[WORD-1] ? -a : a;
                                    mb  = b[WORD-1] ? -b : b;
                                    res = ma / mb;
                                    if (a[WORD-1] ^ b[WORD-1]) res = -res;
                                end
                            end
                            smalu_pkg::OP_LT:
                                res = ($signed(a) < $signed(b)) ? WORD'(1) : WORD'(0);
                            default: res = (a == b) ? WORD'(1) : WORD'(0);
                        endcase
                        if (r.status == smalu_pkg::ST_OK) begin
                            stk_depth--;
                            stk_mem[stk_depth-1] = res;
                        end
                    end
                end
                default: ;
            endcase
        end
        r.depth = smalu_pkg::DEPTH_OUT_W'(stk_depth);
        return r;
    endfunction

    // Append an instruction and track the rough depth for biasing
    task automatic queue_instr(logic [smalu_pkg::REQ_W-1:0] op,
                               logic [smalu_pkg::IMM_W-1:0] imm);
        t_instr it;
        it.op  = op;
        it.imm = imm;
        program_q.push_back(it);
        case (op)
            smalu_pkg::OP_PUSH: if (gen_depth < STACK_N) gen_depth++;
            smalu_pkg::OP_PRINT, smalu_pkg::OP_PRINTLN, smalu_pkg::OP_POP:
                if (gen_depth > 0) gen_depth--;
            smalu_pkg::OP_ADD, smalu_pkg::OP_SUB, smalu_pkg::OP_MUL,
            smalu_pkg::OP_DIV, smalu_pkg::OP_LT, smalu_pkg::OP_EQ:
                if (gen_depth >= 2) gen_depth--;
            default: ;
        endcase
    endtask

    // Operand mix: full random, small signed, extremes, bytes
    function automatic logic [smalu_pkg::IMM_W-1:0] pick_operand();
        logic [smalu_pkg::IMM_W-1:0] v;
        case ($urandom_range(3))
            0: v = $urandom();
            1: v = smalu_pkg::IMM_W'($urandom_range(6)) - smalu_pkg::IMM_W'(3);
            2: begin
                case ($urandom_range(4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 32'hffff_ffff;
                    3: v = 32'h0000_0000;
                    default: v = 32'h0000_0001;
                endcase
            end
            default: v = smalu_pkg::IMM_W'($urandom_range(255));
        endcase
        return v;
    endfunction

    // Idle percentages by thirds of the run: sender first, then receiver
    function automatic int sender_idle_pct();
        if (instr_taken < program_total / 3) return 36;
        if (instr_taken < 2 * program_total / 3) return 51;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (instr_taken < program_total / 3) return 51;
        if (instr_taken < 2 * program_total / 3) return 36;
        return 0;
    endfunction

    // Driver: hold the item until taken, then offer the next or idle
    always @(negedge i_clk) begin
        bit     offer;
        t_instr nxt;
        offer = i_in_valid && !in_fire_q;
        if (!offer && i_rst_n && program_q.size() != 0 &&
            $urandom_range(99) >= sender_idle_pct()) begin
            nxt         = program_q.pop_front();
            i_req_type  <= nxt.op;
            i_immediate <= nxt.imm;
            offer       = 1'b1;
        end
        i_in_valid <= offer;
    end

    // Receiver: random stalls plus one long hold-off late in the run
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!hold_done && results_seen >= 3 * program_total / 4) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < receiver_idle_pct());
        end
    end

    // Monitor: predict on every accepted item, check every result
    always @(posedge i_clk) begin
        t_instr_result want;
        in_fire_q <= in_fire;
        if (in_fire) begin
            retire_q.push_back(execute_instr(i_req_type, i_immediate));
            instr_taken++;
        end
        if (out_fire) begin
            results_seen++;
            if (retire_q.size() == 0) begin
                mismatches++;
                $error("result with no instruction outstanding: status %0d depth %0d",
                       o_status, o_depth_after);
            end else begin
                want = retire_q.pop_front();
                status_hits[want.status]++;
                if (want.kind != smalu_pkg::PK_NONE) prints_seen++;
                if (int'(want.depth) > peak_depth) peak_depth = want.depth;
                if (o_print_kind !== want.kind || o_print_value !== want.value ||
                    o_status !== want.status || o_depth_after !== want.depth) begin
                    mismatches++;
                    if (o_print_kind !== want.kind)
                        $error("print_kind: expected %0d, got %0d",
                               want.kind, o_print_kind);
                    if (o_print_value !== want.value)
                        $error("print_value: expected %0d, got %0d",
                               $signed(want.value), o_print_value);
                    if (o_status !== want.status)
                        $error("status: expected %0d, got %0d", want.status, o_status);
                    if (o_depth_after !== want.depth)
                        $error("depth_after: expected %0d, got %0d",
                               want.depth, o_depth_after);
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (in_fire || out_fire) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                         QUIET_LIMIT, retire_q.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Build the program, release reset, wait for the last result
    initial begin
        int                          target;
        int                          push_pct;
        logic [smalu_pkg::REQ_W-1:0] op;

        // Directed: underflows on a short stack
        queue_instr(smalu_pkg::OP_POP, '0);
        queue_instr(smalu_pkg::OP_PRINTLN, 32'hffff_ffff);
        queue_instr(smalu_pkg::OP_SUB, '0);
        queue_instr(smalu_pkg::OP_PUSH, 32'h7fff_ffff);
        queue_instr(smalu_pkg::OP_MUL, '0);
        // Add wraps to the most negative value, which is then divided by -1
        queue_instr(smalu_pkg::OP_PUSH, 32'h0000_0001);
        queue_instr(smalu_pkg::OP_ADD, '0);
        queue_instr(smalu_pkg::OP_PUSH, 32'hffff_ffff);
        queue_instr(smalu_pkg::OP_DIV, '0);
        // Divide by zero keeps both operands
        queue_instr(smalu_pkg::OP_PUSH, 32'h0000_0000);
        queue_instr(smalu_pkg::OP_DIV, '0);
        queue_instr(smalu_pkg::OP_EQ, '0);
        // Truncating divide of a negative, then a signed compare; then a wrapping multiply, compare, subtract and print
        queue_instr(smalu_pkg::OP_PUSH, 32'hffff_fff9);
        queue_instr(smalu_pkg::OP_PUSH, 32'h0000_0002);
        queue_instr(smalu_pkg::OP_DIV, '0);
        queue_instr(smalu_pkg::OP_LT, '0);
        queue_instr(smalu_pkg::OP_PUSH, 32'hffff_fffe);
        queue_instr(smalu_pkg::OP_PUSH, 32'h8000_0000);
        queue_instr(smalu_pkg::OP_MUL, '0);
        queue_instr(smalu_pkg::OP_EQ, '0);
        queue_instr(smalu_pkg::OP_PUSH, 32'h8000_0000);
        queue_instr(smalu_pkg::OP_SUB, '0);
        queue_instr(smalu_pkg::OP_PRINT, '0);
        // Opcodes that do nothing
        queue_instr(smalu_pkg::OP_BRANCH, 32'h5a5a_a5a5);
        queue_instr(smalu_pkg::OP_NOP, 32'hffff_ffff);
        queue_instr(OP_UNUSED_HI, 32'h8000_0000);
        queue_instr(OP_UNUSED_LO, '0);

        // Random: steer the depth toward moving targets, full stack first
        target = STACK_N;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(99) < 3 ||
                (gen_depth == target && $urandom_range(99) < 15)) begin
                case ($urandom_range(9))
                    0, 1, 2: target = STACK_N;
                    3, 4:    target = $urandom_range(2);
                    default: target = $urandom_range(STACK_N);
                endcase
            end
            push_pct = (gen_depth < target) ? 85 : 15;
            if (gen_depth >= STACK_N && target == STACK_N) push_pct = 40;
            if ($urandom_range(99) < 8) begin
                // Noise: any opcode but halt
                op = smalu_pkg::REQ_W'($urandom_range(smalu_pkg::OP_PUSH, OP_UNUSED_HI));
            end else if ($urandom_range(99) < push_pct) begin
                op = smalu_pkg::OP_PUSH;
            end else begin
                case ($urandom_range(8))
                    0: op = smalu_pkg::OP_PRINT;
                    1: op = smalu_pkg::OP_PRINTLN;
                    2: op = smalu_pkg::OP_POP;
                    3: op = smalu_pkg::OP_ADD;
                    4: op = smalu_pkg::OP_SUB;
                    5: op = smalu_pkg::OP_MUL;
                    6: op = smalu_pkg::OP_DIV;
                    7: op = smalu_pkg::OP_LT;
                    default: op = smalu_pkg::OP_EQ;
                endcase
            end
            queue_instr(op, (op == smalu_pkg::OP_PUSH) ? pick_operand()
                                                       : smalu_pkg::IMM_W'($urandom()));
        end

        // Halt last: everything after it is ignored
        queue_instr(smalu_pkg::OP_HALT, '0);
        queue_instr(smalu_pkg::OP_PUSH, 32'h0000_0007);
        queue_instr(smalu_pkg::OP_ADD, '0);
        queue_instr(smalu_pkg::OP_PRINT, '0);
        queue_instr(smalu_pkg::OP_HALT, '0);
        queue_instr(smalu_pkg::OP_NOP, '0);
        program_total = program_q.size();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (program_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (retire_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Executed %0d instructions, checked %0d results, %0d prints, peak depth %0d",
                 instr_taken, results_seen, prints_seen, peak_depth);
        $display("Status seen: underflow %0d, overflow %0d, divide by zero %0d, halted %0d",
                 status_hits[smalu_pkg::ST_UNDERFLOW], status_hits[smalu_pkg::ST_OVERFLOW],
                 status_hits[smalu_pkg::ST_DIVZERO], status_hits[smalu_pkg::ST_HALTED]);
        if (mismatches == 0 && retire_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/smalu_pkg.sv
sv/smalu_stack_ram.sv
sv/smalu_muldiv.sv
sv/stack_machine_alu_core.sv
tb/sv/tb_top.sv
